@@ sv/rgb_to_hsv_converter_defines.svh @@
// Assertion macros used by the converter top level.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HSV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define HSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsv: next-cycle check failed");

`endif

@@ sv/hsv_pkg.sv @@
// Package: widths, hue constants and the word type handed along the divider chain.
`default_nettype none
package hsv_pkg;

  localparam int ChanW  = 8;
  localparam int HueW   = 15;
  localparam int SatW   = 16;
  localparam int ValW   = 16;
  localparam int WordW  = 24;
  localparam int NumSteps = WordW;

  localparam logic [HueW-1:0] HueSector   = 15'd3840;
  localparam logic [HueW-1:0] HueGreenBase = 15'd7680;
  localparam logic [HueW-1:0] HueBlueBase  = 15'd15360;
  localparam logic [HueW-1:0] HueFullTurn  = 15'd23040;

  // One restoring divider lane: dividend bits shift out at the top while
  // quotient bits shift in at the bottom.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] divisor;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        sat;
    div_lane_t        hue;
    logic [ChanW-1:0] mx;
  } cell_data_t;

endpackage
`default_nettype wire

@@ sv/hsv_if.sv @@
// Interfaces: pixel input channel and HSV result channel.
`default_nettype none
interface hsv_pix_if;
  logic                     valid;
  logic                     ready;
  logic [hsv_pkg::ChanW-1:0] red;
  logic [hsv_pkg::ChanW-1:0] green;
  logic [hsv_pkg::ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hsv_res_if;
  logic                     valid;
  logic                     ready;
  logic [hsv_pkg::HueW-1:0] hue;
  logic [hsv_pkg::SatW-1:0] saturation;
  logic [hsv_pkg::ValW-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface
`default_nettype wire

@@ sv/rgb_to_hsv_converter.sv @@
// Top level: RGB to HSV converter built as a chain of divider cells.
// An accepted pixel word passes the front stage and then every divider cell on its way to res.
// Throughput: one word per cycle while res is ready; a front stage plus 24 restoring-divider
// cells, one quotient bit each, every stage a register with its own valid bit.
// A stalled output only holds stages that are full; empty stages keep filling.
// Reset (rst, synchronous) clears every valid bit; payload registers are not reset.
`default_nettype none
`include "rgb_to_hsv_converter_defines.svh"
module rgb_to_hsv_converter (
  input wire logic clk,
  input wire logic rst,
  hsv_pix_if.sink  pix,
  hsv_res_if.source res
);

  // Chain links: index 0 is the front stage output, index NumSteps the last cell.
  hsv_pkg::cell_data_t link_data  [hsv_pkg::NumSteps+1];
  logic                link_valid [hsv_pkg::NumSteps+1];
  logic                link_ready [hsv_pkg::NumSteps+1];

  // Front stage: find max and min, form chroma, pick the hue sector and
  // build both dividends. Black and grey pixels get zero dividends, and a divisor
  // of one where max or chroma is zero, so the chain yields zero with no special path.
  hsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .red       (pix.red),
    .green     (pix.green),
    .blue      (pix.blue),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0])
  );

  // Divider chain: each cell brings down one dividend bit and settles one
  // quotient bit for saturation and hue side by side.
  for (genvar i = 0; i < hsv_pkg::NumSteps; i++) begin : g_cell
    hsv_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  // Last cell doubles as the output register: its word now holds the quotient.
  assign link_ready[hsv_pkg::NumSteps] = res.ready;
  assign res.valid      = link_valid[hsv_pkg::NumSteps];
  assign res.hue        = link_data[hsv_pkg::NumSteps].hue.word[hsv_pkg::HueW-1:0];
  assign res.saturation = link_data[hsv_pkg::NumSteps].sat.word[hsv_pkg::SatW-1:0];
  // max * 257 is max repeated in both bytes
  assign res.brightness = {link_data[hsv_pkg::NumSteps].mx,
                           link_data[hsv_pkg::NumSteps].mx};

  // Hue never reaches a full turn.
  `HSV_ASSERT_NOW(a_hue_range, res.valid, res.hue < hsv_pkg::HueFullTurn)
  // A black pixel carries no hue and no saturation.
  `HSV_ASSERT_NOW(a_black_zero, res.valid && (res.brightness == '0),
                  (res.hue == '0) && (res.saturation == '0))
  // A coloured hue implies non-zero chroma, hence non-zero saturation.
  `HSV_ASSERT_NOW(a_hue_needs_sat, res.valid && (res.hue != '0), res.saturation != '0)
  // An accepted pixel lands in the front stage on the next edge.
  `HSV_ASSERT_NEXT(a_front_load, pix.valid && pix.ready, link_valid[0])

endmodule
`default_nettype wire

@@ sv/hsv_prep.sv @@
// Front stage: max, min, chroma and the two dividends and divisors.
`default_nettype none
module hsv_prep (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [hsv_pkg::ChanW-1:0] red,
  input  wire logic [hsv_pkg::ChanW-1:0] green,
  input  wire logic [hsv_pkg::ChanW-1:0] blue,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      hsv_pkg::cell_data_t       out_data
);

  logic [hsv_pkg::ChanW-1:0] mx;
  logic [hsv_pkg::ChanW-1:0] mn;
  logic [hsv_pkg::ChanW-1:0] chroma;
  logic signed [8:0]         diff;
  logic [hsv_pkg::HueW-1:0]  base;
  logic [22:0]               prod_base;
  logic signed [21:0]        diff_scaled;
  logic [25:0]               num_hue;
  hsv_pkg::cell_data_t       data_next;

  always_comb begin
    mx = (red > green) ? red : green;
    mn = (red < green) ? red : green;
    if (blue > mx) begin
      mx = blue;
    end
    if (blue < mn) begin
      mn = blue;
    end
    chroma = mx - mn;

    // Red wins ties over green, green over blue.
    priority if (mx == red) begin
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
      base = diff[8] ? hsv_pkg::HueFullTurn : '0;
    end else if (mx == green) begin
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
      base = hsv_pkg::HueGreenBase;
    end else begin
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
      base = hsv_pkg::HueBlueBase;
    end

    prod_base   = {8'b0, base} * {15'b0, chroma};
    diff_scaled = 22'(diff) * $signed({7'b0, hsv_pkg::HueSector});
    num_hue     = {3'b000, prod_base} + {{4{diff_scaled[21]}}, diff_scaled};

    data_next.mx          = mx;
    data_next.sat.rem     = '0;
    data_next.hue.rem     = '0;
    // chroma * 65535 as a shift and subtract
    data_next.sat.word    = {chroma, 16'b0} - {16'b0, chroma};
    data_next.sat.divisor = (mx == '0) ? 8'd1 : mx;
    if (chroma == '0) begin
      data_next.hue.word    = '0;
      data_next.hue.divisor = 8'd1;
    end else begin
      data_next.hue.word    = num_hue[hsv_pkg::WordW-1:0];
      data_next.hue.divisor = chroma;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/hsv_div_cell.sv @@
// Divider cell: one restoring step on both lanes, then register and hand on.
`default_nettype none
module hsv_div_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire hsv_pkg::cell_data_t in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      hsv_pkg::cell_data_t out_data
);

  function automatic hsv_pkg::div_lane_t div_step(input hsv_pkg::div_lane_t lane);
    logic [8:0]         trial;
    logic [8:0]         left;
    logic               q;
    hsv_pkg::div_lane_t res;
    trial = {lane.rem, lane.word[hsv_pkg::WordW-1]};
    left  = trial - {1'b0, lane.divisor};
    q     = (trial >= {1'b0, lane.divisor});
    res.rem     = q ? left[7:0] : trial[7:0];
    res.word    = {lane.word[hsv_pkg::WordW-2:0], q};
    res.divisor = lane.divisor;
    return res;
  endfunction

  hsv_pkg::cell_data_t data_next;

  always_comb begin
    data_next.mx  = in_data.mx;
    data_next.sat = div_step(in_data.sat);
    data_next.hue = div_step(in_data.hue);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

@@ tb/rgb_to_hsv_converter_test.sv @@
// Testbench for rgb_to_hsv_converter: directed and random pixels checked against a predictor.
module rgb_to_hsv_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ChanW = hsv_pkg::ChanW;
  localparam int HueW  = hsv_pkg::HueW;
  localparam int SatW  = hsv_pkg::SatW;
  localparam int ValW  = hsv_pkg::ValW;

  localparam int ResetCycles    = 8;
  localparam int RandomWords    = 630;
  // Long result hold-off: start it once this many pixel words are in, keep it this long.
  localparam int HoldAfterWords = 200;
  localparam int HoldCycles     = 150;
  // Quiet cycles after the last result.
  localparam int TailCycles     = 40;
  // Worst quiet stretch is the hold-off plus the pipeline plus a long gap; allow plenty more.
  localparam int WatchdogLimit  = 2000;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] saturation;
    logic [ValW-1:0] brightness;
  } hsv_word_t;

  typedef struct {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    int               gap_after;   // idle cycles after this word
    bit               drain_first; // hold this word until every result is back
  } pixel_job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hsv_pix_if pix ();
  hsv_res_if res ();

  rgb_to_hsv_converter dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res)
  );

  pixel_job_t pending_pixels[$];
  hsv_word_t  expected_hsv[$];

  int   words_in     = 0;
  int   words_out    = 0;
  int   failures     = 0;
  int   idle_cycles  = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   stall_pct    = 0;
  int   pace_cycles  = 0;
  int   hold_count   = 0;
  logic hold_off     = 1'b0;
  logic hold_done    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict hue, saturation and value of one pixel.
  // Hue is in 1/64 degree: each 60 degree sector spans HueSector units, and the red
  // sector wraps a negative green-minus-blue by a full turn before the division.
  function automatic hsv_word_t hsv_of(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                       logic [ChanW-1:0] b);
    int        rv, gv, bv, mx, mn, chroma, num;
    hsv_word_t w;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    mx = (rv > gv) ? rv : gv;
    mn = (rv < gv) ? rv : gv;
    if (bv > mx) mx = bv;
    if (bv < mn) mn = bv;
    chroma = mx - mn;
    w = '0;
    // A black pixel leaves everything at zero; a grey one keeps hue at zero.
    if (mx != 0) begin
      w.brightness = ValW'(mx * 257);
      w.saturation = SatW'((chroma * 65535) / mx);
      if (chroma != 0) begin
        // Red wins ties over green, green over blue.
        if (mx == rv) begin
          num = int'(hsv_pkg::HueSector) * (gv - bv);
          if (gv < bv) num += int'(hsv_pkg::HueFullTurn) * chroma;
        end else if (mx == gv) begin
          num = int'(hsv_pkg::HueGreenBase) * chroma + int'(hsv_pkg::HueSector) * (bv - rv);
        end else begin
          num = int'(hsv_pkg::HueBlueBase) * chroma + int'(hsv_pkg::HueSector) * (rv - gv);
        end
        if (num < 0) num = 0;
        w.hue = HueW'(num / chroma);
      end
    end
    return w;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      failures++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Queue one pixel word; calm words follow each other with no gap.
  task automatic queue_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b,
                             bit drain, bit calm);
    pixel_job_t job;
    int         pick;
    job.red         = r;
    job.green       = g;
    job.blue        = b;
    job.drain_first = drain;
    pick = $urandom_range(0, 99);
    // Mostly back to back or short gaps, now and then a long one.
    if (calm || pick < 55) job.gap_after = 0;
    else if (pick < 90)    job.gap_after = $urandom_range(1, 3);
    else                   job.gap_after = $urandom_range(8, 40);
    pending_pixels.push_back(job);
  endtask

  // Pixel driver: offer the next pending word, hold it while the input is stalled,
  // and record the prediction at the edge that accepts it.
  always @(posedge clk) begin : drive_pixels
    pixel_job_t job;
    if (rst) begin
      pix.valid <= 1'b0;
      words_in  <= 0;
      gap_left   = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        expected_hsv.push_back(hsv_of(pix.red, pix.green, pix.blue));
        words_in <= words_in + 1;
      end
      if (!pix.valid || pix.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix.valid <= 1'b0;
        end else if (pending_pixels.size() != 0 &&
                     !(pending_pixels[0].drain_first &&
                       (pix.valid || words_in != words_out))) begin
          // A drain word waits until nothing is in flight: nothing accepted at this
          // edge and every earlier word has its result back.
          job = pending_pixels.pop_front();
          pix.valid <= 1'b1;
          pix.red   <= job.red;
          pix.green <= job.green;
          pix.blue  <= job.blue;
          gap_left   = job.gap_after;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Long result hold-off: once enough words are in, drop ready for HoldCycles while
  // the driver keeps offering, so that the pipeline fills and stalls its input.
  always @(posedge clk) begin : hold_results
    if (rst) begin
      hold_off   <= 1'b0;
      hold_done  <= 1'b0;
      hold_count <= 0;
    end else if (hold_off) begin
      if (hold_count == HoldCycles - 1) begin
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else if (!hold_done && words_in >= HoldAfterWords) begin
      hold_off   <= 1'b1;
      hold_count <= 0;
    end
  end

  // Result monitor: compare each accepted result word with the oldest prediction,
  // and pace ready with random stalls whose rate is redrawn among 0, 12 and 40 percent.
  always @(posedge clk) begin : check_results
    hsv_word_t want;
    if (rst) begin
      res.ready  <= 1'b0;
      words_out  <= 0;
      stall_left  = 0;
      stall_pct   = 0;
      pace_cycles = 0;
    end else begin
      if (res.valid && res.ready) begin
        words_out <= words_out + 1;
        if (expected_hsv.size() == 0) begin
          failures++;
          $error("result word with nothing expected: hue %0d saturation %0d brightness %0d",
                 res.hue, res.saturation, res.brightness);
        end else begin
          want = expected_hsv.pop_front();
          check_field("hue", want.hue, res.hue);
          check_field("saturation", want.saturation, res.saturation);
          check_field("brightness", want.brightness, res.brightness);
        end
      end
      pace_cycles++;
      if (pace_cycles % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 12;
          default: stall_pct = 40;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
      res.ready <= !hold_off && stall_left == 0;
    end
  end

  // Watchdog: end the run when neither channel moves a word for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("timeout after %0d quiet cycles", WatchdogLimit);
      $display("rgb_to_hsv_converter verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int               kind, shape;
    logic [ChanW-1:0] r, g, b, v, u;
    bit               calm;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    res.ready = 1'b0;

    // Directed corners: black, greys, primaries, tie-breaks and both signs per sector.
    queue_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    queue_pixel(8'd1,   8'd1,   8'd1,   1'b0, 1'b0);
    queue_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd0,   1'b0, 1'b0);
    queue_pixel(8'd0,   8'd255, 8'd0,   1'b0, 1'b0);
    queue_pixel(8'd0,   8'd0,   8'd255, 1'b0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd0,   1'b0, 1'b0); // red beats green
    queue_pixel(8'd0,   8'd255, 8'd255, 1'b0, 1'b0); // green beats blue
    queue_pixel(8'd255, 8'd0,   8'd255, 1'b0, 1'b0); // red beats blue, wraps
    queue_pixel(8'd255, 8'd0,   8'd1,   1'b0, 1'b0); // red, just below a full turn
    queue_pixel(8'd255, 8'd1,   8'd0,   1'b0, 1'b0);
    queue_pixel(8'd200, 8'd100, 8'd100, 1'b0, 1'b0); // red, zero difference
    queue_pixel(8'd1,   8'd0,   8'd0,   1'b0, 1'b0); // smallest chroma
    queue_pixel(8'd0,   8'd1,   8'd0,   1'b0, 1'b0);
    queue_pixel(8'd0,   8'd0,   8'd1,   1'b0, 1'b0);
    queue_pixel(8'd10,  8'd200, 8'd50,  1'b0, 1'b0);
    queue_pixel(8'd50,  8'd200, 8'd10,  1'b0, 1'b0);
    queue_pixel(8'd10,  8'd50,  8'd200, 1'b0, 1'b0);
    queue_pixel(8'd50,  8'd10,  8'd200, 1'b0, 1'b0);
    queue_pixel(8'd255, 8'd254, 8'd254, 1'b0, 1'b0);
    queue_pixel(8'd254, 8'd255, 8'd255, 1'b0, 1'b0);
    queue_pixel(8'd170, 8'd85,  8'd0,   1'b0, 1'b0);

    // Random pixels: uniform colours plus tied channels, greys, extremes and tiny
    // values. Two calm stretches run with no gaps; the first of them carries the
    // long result hold-off. Two words wait for the pipeline to drain first.
    for (int i = 0; i < RandomWords; i++) begin
      kind = $urandom_range(0, 99);
      v    = ChanW'($urandom);
      u    = ChanW'($urandom);
      r    = ChanW'($urandom);
      g    = ChanW'($urandom);
      b    = ChanW'($urandom);
      if (kind < 50) begin
        // keep the uniform draw
      end else if (kind < 65) begin
        shape = $urandom_range(0, 2);
        r = (shape == 0) ? u : v;
        g = (shape == 1) ? u : v;
        b = (shape == 2) ? u : v;
      end else if (kind < 73) begin
        r = v;
        g = v;
        b = v;
      end else if (kind < 85) begin
        if ($urandom_range(0, 2) == 0) r = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        if ($urandom_range(0, 2) == 0) g = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        if ($urandom_range(0, 2) == 0) b = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      end else begin
        r = ChanW'($urandom_range(0, 3));
        g = ChanW'($urandom_range(0, 3));
        b = ChanW'($urandom_range(0, 3));
      end
      calm = (i >= 160 && i < 260) || (i >= 500 && i < 540);
      queue_pixel(r, g, b, i == 0 || i == 420, calm);
    end

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last word in and its result out, then let the pipeline run dry.
    // Sample on the falling edge so every update of the rising edge has settled.
    while (!(pending_pixels.size() == 0 && !pix.valid && words_in == words_out))
      @(negedge clk);
    repeat (TailCycles) @(posedge clk);

    if (expected_hsv.size() != 0) begin
      failures++;
      $error("%0d predicted result words never arrived", expected_hsv.size());
    end

    $display("run: %0d pixel words in, %0d result words checked", words_in, words_out);
    $display("run: corners, greys, tied channels, random colours, %0d-cycle result hold-off",
             HoldCycles);
    if (failures == 0) begin
      $display("rgb_to_hsv_converter verification clean");
    end else begin
      $display("rgb_to_hsv_converter verification failed");
    end
    $finish;
  end

endmodule
